// ===== design/mseu_pkg.sv =====
package mseu_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW = $clog2(MEM_WORDS);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_AND = 5'd2, OP_BEQ = 5'd3, OP_BGTZ = 5'd4,
    OP_BLEZ = 5'd5, OP_BNE = 5'd6, OP_DIV = 5'd7, OP_J = 5'd8, OP_JAL = 5'd9,
    OP_JR = 5'd10, OP_LUI = 5'd11, OP_LW = 5'd12, OP_MFHI = 5'd13, OP_MFLO = 5'd14,
    OP_MULT = 5'd15, OP_OR = 5'd16, OP_ROTR = 5'd17, OP_SLL = 5'd18, OP_SLT = 5'd19,
    OP_SRL = 5'd20, OP_SUB = 5'd21, OP_SW = 5'd22, OP_XOR = 5'd23
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RB, S_RA, S_EXEC, S_MUL, S_DIV, S_DIVF
  } state_t;

  typedef enum logic [1:0] {
    FIN_EXEC, FIN_MUL, FIN_DIV, FIN_MEM
  } fin_kind_t;

  typedef struct packed {
    logic      clear;
    logic      accept;
    logic      latch_bc;
    logic      latch_a;
    logic      mul;
    logic      div_start;
    logic      div_step;
    logic      finish;
    fin_kind_t kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic misaligned;
    logic div_zero;
    logic div_last;
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/mseu_ctrl.sv =====
module mseu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  mseu_pkg::sts_t sts,
  output logic           s_tready,
  output mseu_pkg::cmd_t cmd
);

  mseu_pkg::state_t state, state_next;
  logic mem_wait, mem_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mseu_pkg::S_CLEAR;
      mem_wait <= 1'b0;
    end else begin
      state <= state_next;
      mem_wait <= mem_wait_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_wait_next = mem_wait;
    s_tready = 1'b0;
    cmd = '0;
    cmd.kind = mseu_pkg::FIN_EXEC;
    case (state)
      mseu_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = mseu_pkg::S_IDLE;
      end
      mseu_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = mseu_pkg::S_RB;
        end
      end
      mseu_pkg::S_RB: begin
        cmd.latch_bc = 1'b1;
        state_next = mseu_pkg::S_RA;
      end
      mseu_pkg::S_RA: begin
        cmd.latch_a = 1'b1;
        state_next = mseu_pkg::S_EXEC;
      end
      mseu_pkg::S_EXEC: begin
        if (mem_wait) begin
          cmd.kind = mseu_pkg::FIN_MEM;
          if (sts.out_free) begin
            cmd.finish = 1'b1;
            mem_wait_next = 1'b0;
            state_next = mseu_pkg::S_IDLE;
          end
        end else begin
          case (sts.op)
            mseu_pkg::OP_MULT: begin
              cmd.mul = 1'b1;
              state_next = mseu_pkg::S_MUL;
            end
            mseu_pkg::OP_DIV: begin
              if (!sts.div_zero) begin
                cmd.div_start = 1'b1;
                state_next = mseu_pkg::S_DIV;
              end else if (sts.out_free) begin
                cmd.finish = 1'b1;
                state_next = mseu_pkg::S_IDLE;
              end
            end
            mseu_pkg::OP_LW: begin
              if (!sts.misaligned) begin
                mem_wait_next = 1'b1;
              end else if (sts.out_free) begin
                cmd.finish = 1'b1;
                state_next = mseu_pkg::S_IDLE;
              end
            end
            default: begin
              if (sts.out_free) begin
                cmd.finish = 1'b1;
                state_next = mseu_pkg::S_IDLE;
              end
            end
          endcase
        end
      end
      mseu_pkg::S_MUL: begin
        cmd.kind = mseu_pkg::FIN_MUL;
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = mseu_pkg::S_IDLE;
        end
      end
      mseu_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = mseu_pkg::S_DIVF;
      end
      mseu_pkg::S_DIVF: begin
        cmd.kind = mseu_pkg::FIN_DIV;
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = mseu_pkg::S_IDLE;
        end
      end
      default: state_next = mseu_pkg::S_CLEAR;
    endcase
  end

endmodule

// ===== design/mseu_dp.sv =====
module mseu_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic [71:0]    s_tdata,
  input  logic           m_tready,
  input  mseu_pkg::cmd_t cmd,
  output mseu_pkg::sts_t sts,
  output logic           m_tvalid,
  output logic [135:0]   m_tdata
);

  localparam int AW = mseu_pkg::MEM_AW;

  logic [4:0]  op_q, ra_q, rc_q, sa_q;
  logic [15:0] imm_q;
  logic [25:0] jt_q;
  logic [31:0] a_q, b_q, c_q;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;
  logic [4:0]  rf_addr0, rf_addr1;
  logic [31:0] rf_data0, rf_data1;
  logic        rf_ok0, rf_ok1;
  logic [31:0] rd0, rd1;

  logic [31:0] dm_mem [mseu_pkg::MEM_WORDS];
  logic [AW-1:0] clr_cnt, dm_idx, dm_waddr;
  logic [31:0] dm_rdata, dm_wdata;
  logic        dm_we;

  logic [31:0] hi, lo, pc, bt;
  logic        bp;
  logic [63:0] prod;

  logic [31:0] rem, quo, mb;
  logic [4:0]  div_cnt;
  logic        div_na, div_nb;
  logic [32:0] div_sh, div_diff;

  logic [31:0] imm_s, addr, pc4, next_pc, boff, target, wval, hi_n, lo_n;
  logic        take, wen_raw, wen;
  logic [4:0]  widx;
  logic [1:0]  status;
  logic [63:0] rot;

  logic        out_valid;
  logic [1:0]  o_status;
  logic [31:0] o_pc, o_wval, o_hi, o_lo;
  logic        o_wen;
  logic [4:0]  o_widx;

  assign imm_s = {{16{imm_q[15]}}, imm_q};
  assign addr = c_q + imm_s;
  assign pc4 = pc + 32'd4;
  assign next_pc = bp ? bt : pc4;
  assign boff = pc4 + {imm_s[29:0], 2'b00};
  assign rot = {b_q, b_q} >> sa_q;
  assign dm_idx = addr[AW+1:2];
  assign rd0 = rf_ok0 ? rf_data0 : 32'd0;
  assign rd1 = rf_ok1 ? rf_data1 : 32'd0;

  always_comb begin
    if (cmd.accept) begin
      rf_addr0 = s_tdata[14:10];
      rf_addr1 = s_tdata[19:15];
    end else begin
      rf_addr0 = ra_q;
      rf_addr1 = rc_q;
    end
  end

  always_ff @(posedge clk) begin
    rf_data0 <= rf_mem[rf_addr0];
    rf_data1 <= rf_mem[rf_addr1];
    rf_ok0 <= rf_valid[rf_addr0];
    rf_ok1 <= rf_valid[rf_addr1];
    if (cmd.finish && wen) rf_mem[widx] <= wval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (cmd.finish && wen) begin
      rf_valid[widx] <= 1'b1;
    end
  end

  always_comb begin
    dm_we = cmd.clear;
    dm_waddr = clr_cnt;
    dm_wdata = 32'd0;
    if (cmd.finish && cmd.kind == mseu_pkg::FIN_EXEC &&
        op_q == mseu_pkg::OP_SW && addr[1:0] == 2'b00) begin
      dm_we = 1'b1;
      dm_waddr = dm_idx;
      dm_wdata = a_q;
    end
  end

  always_ff @(posedge clk) begin
    dm_rdata <= dm_mem[dm_idx];
    if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= s_tdata[4:0];
      ra_q <= s_tdata[9:5];
      rc_q <= s_tdata[19:15];
      imm_q <= s_tdata[35:20];
      sa_q <= s_tdata[40:36];
      jt_q <= s_tdata[66:41];
    end
    if (cmd.latch_bc) begin
      b_q <= rd0;
      c_q <= rd1;
    end
    if (cmd.latch_a) a_q <= rd0;
    if (cmd.mul) prod <= $signed(a_q) * $signed(b_q);
  end

  assign div_sh = {rem, quo[31]};
  assign div_diff = div_sh - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_na <= a_q[31];
      div_nb <= b_q[31];
      rem <= 32'd0;
      quo <= a_q[31] ? 32'd0 - a_q : a_q;
      mb <= b_q[31] ? 32'd0 - b_q : b_q;
      div_cnt <= 5'd0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 5'd1;
      if (!div_diff[32]) begin
        rem <= div_diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= div_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    take = 1'b0;
    target = boff;
    status = mseu_pkg::ST_OK;
    wen_raw = 1'b0;
    widx = ra_q;
    wval = 32'd0;
    hi_n = hi;
    lo_n = lo;
    case (op_q)
      mseu_pkg::OP_ADD: begin wen_raw = 1'b1; wval = b_q + c_q; end
      mseu_pkg::OP_ADDI: begin wen_raw = 1'b1; wval = b_q + imm_s; end
      mseu_pkg::OP_AND: begin wen_raw = 1'b1; wval = b_q & c_q; end
      mseu_pkg::OP_OR: begin wen_raw = 1'b1; wval = b_q | c_q; end
      mseu_pkg::OP_XOR: begin wen_raw = 1'b1; wval = b_q ^ c_q; end
      mseu_pkg::OP_SUB: begin wen_raw = 1'b1; wval = b_q - c_q; end
      mseu_pkg::OP_SLT: begin
        wen_raw = 1'b1;
        wval = {31'd0, $signed(b_q) < $signed(c_q)};
      end
      mseu_pkg::OP_SLL: begin wen_raw = 1'b1; wval = b_q << sa_q; end
      mseu_pkg::OP_SRL: begin wen_raw = 1'b1; wval = b_q >> sa_q; end
      mseu_pkg::OP_ROTR: begin wen_raw = 1'b1; wval = rot[31:0]; end
      mseu_pkg::OP_LUI: begin wen_raw = 1'b1; wval = {imm_q, 16'd0}; end
      mseu_pkg::OP_MFHI: begin wen_raw = 1'b1; wval = hi; end
      mseu_pkg::OP_MFLO: begin wen_raw = 1'b1; wval = lo; end
      mseu_pkg::OP_BEQ: take = (a_q == b_q);
      mseu_pkg::OP_BNE: take = (a_q != b_q);
      mseu_pkg::OP_BGTZ: take = (a_q != 32'd0) && !a_q[31];
      mseu_pkg::OP_BLEZ: take = (a_q == 32'd0) || a_q[31];
      mseu_pkg::OP_J: begin
        take = 1'b1;
        target = {pc4[31:28], jt_q, 2'b00};
      end
      mseu_pkg::OP_JAL: begin
        take = 1'b1;
        target = {pc4[31:28], jt_q, 2'b00};
        wen_raw = 1'b1;
        widx = 5'd31;
        wval = pc + 32'd8;
      end
      mseu_pkg::OP_JR: begin
        if (a_q[1:0] != 2'b00) begin
          status = mseu_pkg::ST_ADDR_ERR;
        end else begin
          take = 1'b1;
          target = a_q;
        end
      end
      mseu_pkg::OP_LW: begin
        if (addr[1:0] != 2'b00) begin
          status = mseu_pkg::ST_ADDR_ERR;
        end else begin
          wen_raw = (cmd.kind == mseu_pkg::FIN_MEM);
          wval = dm_rdata;
        end
      end
      mseu_pkg::OP_SW: begin
        if (addr[1:0] != 2'b00) status = mseu_pkg::ST_ADDR_ERR;
      end
      mseu_pkg::OP_DIV: begin
        if (b_q == 32'd0) begin
          status = mseu_pkg::ST_DIV_ZERO;
        end else if (cmd.kind == mseu_pkg::FIN_DIV) begin
          lo_n = (div_na != div_nb) ? 32'd0 - quo : quo;
          hi_n = div_na ? 32'd0 - rem : rem;
        end
      end
      mseu_pkg::OP_MULT: begin
        if (cmd.kind == mseu_pkg::FIN_MUL) begin
          hi_n = prod[63:32];
          lo_n = prod[31:0];
        end
      end
      default: ;
    endcase
    wen = wen_raw && (widx != 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= 32'd0;
      lo <= 32'd0;
      pc <= 32'd0;
      bp <= 1'b0;
      bt <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        hi <= hi_n;
        lo <= lo_n;
        pc <= next_pc;
        bp <= take;
        if (take) bt <= target;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_status <= status;
      o_pc <= next_pc;
      o_wen <= wen;
      o_widx <= wen ? widx : 5'd0;
      o_wval <= wen ? wval : 32'd0;
      o_hi <= hi_n;
      o_lo <= lo_n;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {o_lo, o_hi, o_wval, o_widx, o_wen, o_pc, o_status};

  assign sts.op = mseu_pkg::op_t'(op_q);
  assign sts.misaligned = (addr[1:0] != 2'b00);
  assign sts.div_zero = (b_q == 32'd0);
  assign sts.div_last = (div_cnt == 5'd31);
  assign sts.clear_last = (clr_cnt == AW'(mseu_pkg::MEM_WORDS - 1));
  assign sts.out_free = !out_valid || m_tready;

endmodule

// ===== design/mips_subset_execute_unit_core.sv =====
// Execute unit for a subset of 32-bit integer instructions, one decoded
// instruction per item. The slave channel takes an instruction; the master
// channel returns one result item for each, in order.
// After reset the data memory is cleared, one word per cycle for all MEM_WORDS
// (1024) words, during which s_tready stays low.
// One item is in work at a time: s_tready is high only while the unit is idle.
// An accepted item reads its reg_b and reg_c operands, then its reg_a operand,
// from the two-port register file, then executes. Most operations show their
// result on the master channel and the unit is ready again in the same cycle.
// mult finishes after its product is registered and an aligned lw after its
// registered memory read; div by a nonzero divisor runs the bit-serial divider,
// one quotient bit a cycle, before its result goes out.
// The result sits in an output register; when the receiver stalls it holds
// there and the next instruction is executed up to its result and waits
// until that register is taken.
module mips_subset_execute_unit_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, reg_a, reg_b, reg_c, immediate, shift_amount, jump_target, zero fill
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, pc_after, reg_written, written_index, written_value, hi_value, lo_value
  output logic [135:0] m_tdata
);

  mseu_pkg::cmd_t cmd;
  mseu_pkg::sts_t sts;

  mseu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  mseu_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in work");

  a_write_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> m_tdata[39:35] != 5'd0)
    else $error("register zero reported as written");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[34] |-> m_tdata[39:35] == 5'd0 && m_tdata[71:40] == 32'd0)
    else $error("write fields not cleared without a write");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("undefined status code");

endmodule
